// ----- rtl/sckd_pkg.sv -----
// Package for the serial command and key event decoder.
// Holds field widths, character codes, header strings and shared types.
// No dependencies.
package sckd_pkg;

  localparam int ByteW      = 8;
  localparam int FrameLen   = 9;
  localparam int StoreDepth = FrameLen - 1;   // last byte of a frame is used as it arrives
  localparam int PosW       = 4;
  localparam int StoreIdxW  = 3;
  localparam int HeaderLen  = 7;
  localparam int NumHeaders = 5;
  localparam int TargetW    = 3;
  localparam int ValueW     = 13;

  typedef logic [ByteW-1:0] char_t;

  // Character codes
  localparam char_t CharNone = 8'h00;
  localparam char_t CharP    = 8'h50;  // 'P' restarts a frame
  localparam char_t CharD    = 8'h64;  // 'd' right
  localparam char_t CharA    = 8'h61;  // 'a' left
  localparam char_t CharE    = 8'h65;  // 'e' enter

  // (b7 - '0') * 10 + (b8 - '0') = b7 * 10 + b8 - 11 * '0'
  localparam logic [ValueW-1:0] ValueBias = ValueW'(11 * 48);

  // Frame headers, first character in the top byte; index is the target code
  localparam logic [HeaderLen*ByteW-1:0] Headers [NumHeaders] = '{
    "PSMAX1X",
    "PSMAX2X",
    "PSMIN1X",
    "PSMIN2X",
    "PSTIMEX"
  };

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvRight = 2'd1,
    EvLeft  = 2'd2,
    EvEnter = 2'd3
  } event_t;

  // Frame decode outcome for the current transaction
  typedef struct packed {
    logic                     command_valid;
    logic [TargetW-1:0]       command_target;
    logic signed [ValueW-1:0] command_value;
  } frame_res_t;

endpackage

// ----- rtl/sckd_if.sv -----
// Valid/ready channel interfaces for the decoder: button/serial samples in, results out.
// Depends on sckd_pkg.
interface sckd_sample_if
  import sckd_pkg::*;
;
  logic        valid;
  logic        ready;
  logic        button_right;
  logic        button_left;
  logic        button_enter;
  char_t       serial_byte;

  modport source (output valid, output button_right, output button_left,
                  output button_enter, output serial_byte, input ready);
  modport sink   (input valid, input button_right, input button_left,
                  input button_enter, input serial_byte, output ready);
endinterface

interface sckd_result_if
  import sckd_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               event_code;
  logic                     command_valid;
  logic [TargetW-1:0]       command_target;
  logic signed [ValueW-1:0] command_value;

  modport source (output valid, output event_code, output command_valid,
                  output command_target, output command_value, input ready);
  modport sink   (input valid, input event_code, input command_valid,
                  input command_target, input command_value, output ready);
endinterface

// ----- rtl/sckd_frame.sv -----
// Frame assembler: stores serial bytes, tracks position, matches headers, forms value.
// Depends on sckd_pkg.
module sckd_frame
  import sckd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  char_t      serial_byte,
  output frame_res_t res
);

  char_t           store [StoreDepth];
  logic [PosW-1:0] position;
  logic [PosW-1:0] position_next;
  logic [PosW-1:0] base;
  logic            has_byte;
  logic            complete;
  logic            store_wr;
  logic [HeaderLen*ByteW-1:0] header;
  logic [ValueW-1:0] tens;
  logic [ValueW-1:0] value_sum;

  // Write position: 'P' (or an out-of-range count) starts from zero
  always_comb begin
    has_byte = (serial_byte != CharNone);
    if (serial_byte == CharP || position >= PosW'(FrameLen)) begin
      base = '0;
    end else begin
      base = position;
    end
    complete = has_byte && (base == PosW'(FrameLen - 1));
    store_wr = has_byte && !complete;
    if (!has_byte) begin
      position_next = position;
    end else if (complete) begin
      position_next = '0;
    end else begin
      position_next = base + PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      position <= position_next;
    end
  end

  // Byte store, no reset: every entry is written before a frame completes
  always_ff @(posedge clk) begin
    if (accept && store_wr) begin
      store[base[StoreIdxW-1:0]] <= serial_byte;
    end
  end

  // Header match and value; the ninth byte is taken straight from the input
  always_comb begin
    header = {store[0], store[1], store[2], store[3], store[4], store[5], store[6]};
    tens      = {{(ValueW-ByteW){1'b0}}, store[7]};
    value_sum = (tens << 3) + (tens << 1) + {{(ValueW-ByteW){1'b0}}, serial_byte} - ValueBias;
    res = '0;
    if (complete) begin
      for (int h = NumHeaders - 1; h >= 0; h--) begin
        if (header == Headers[h]) begin
          res.command_valid  = 1'b1;
          res.command_target = TargetW'(h);
          res.command_value  = value_sum;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= PosW'(FrameLen - 1))
    else $error("frame position out of range");

  a_complete_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && complete |=> position == '0)
    else $error("position not cleared after complete frame");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && serial_byte == CharP |=> position == PosW'(1))
    else $error("'P' did not restart the frame");
`endif

endmodule

// ----- rtl/serial_command_and_key_event_decoder_top.sv -----
// Top level of the serial command and key event decoder.
// Depends on sckd_pkg, sckd_if (sckd_sample_if, sckd_result_if) and sckd_frame.
//
// Usage:
//   sample : one transaction per button sample and received serial byte
//            (serial_byte 0 means no character).
//   result : exactly one transaction per sample: the key event (enter over
//            left over right, overridden by 'd', 'a', 'e') and, when the
//            sample completes a nine-byte frame with a known header, the
//            selected setting and its two-digit value.
//   The result is in the output register the cycle after the sample is
//   taken. One sample is taken per cycle while the receiver drains results;
//   the frame store and header compare sit in one combinational pass ahead of
//   the result register.
//   sample.ready is high while the result register is empty or being
//   drained, so a stalled receiver holds the result and blocks only new
//   samples.
//   Reset (rst, synchronous) empties the result register and returns the
//   frame position to zero; stored frame bytes are kept.
module serial_command_and_key_event_decoder_top
  import sckd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sckd_sample_if.sink   sample,
  sckd_result_if.source result
);

  logic       accept;
  logic       res_valid;
  event_t     ev;
  frame_res_t frame_res;

  assign sample.ready = !res_valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  sckd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .serial_byte (sample.serial_byte),
    .res         (frame_res)
  );

  // Key event: button priority, then serial command override
  always_comb begin
    ev = EvNone;
    if (sample.button_right) ev = EvRight;
    if (sample.button_left)  ev = EvLeft;
    if (sample.button_enter) ev = EvEnter;
    case (sample.serial_byte)
      CharD:   ev = EvRight;
      CharA:   ev = EvLeft;
      CharE:   ev = EvEnter;
      default: ;
    endcase
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result.event_code     <= ev;
      result.command_valid  <= frame_res.command_valid;
      result.command_target <= frame_res.command_target;
      result.command_value  <= frame_res.command_value;
    end
  end

  assign result.valid = res_valid;

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> sample.ready)
    else $error("sample blocked with empty result register");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.command_valid |-> result.command_target <= TargetW'(NumHeaders - 1))
    else $error("command target out of range");

  a_no_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.command_valid |->
      result.command_target == '0 && result.command_value == '0)
    else $error("target or value set without a command");

  a_serial_override: assert property (@(posedge clk) disable iff (rst)
    accept && sample.serial_byte == CharD |=> res_valid && result.event_code == EvRight)
    else $error("'d' did not give a right event");
`endif

endmodule

// ----- bench/serial_command_and_key_event_decoder_top_test.sv -----
// Testbench for serial_command_and_key_event_decoder_top: directed table, then random frames.
// Results are checked against fixed table values or a predictor of key events and frame commands.
// Depends on sckd_pkg, sckd_if and the RTL top level.
module serial_command_and_key_event_decoder_top_test
  import sckd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalItems  = 650;
  localparam int CalmFrom    = 560;      // no idling on either side from here on
  localparam int CycleLimit  = 200000;
  localparam int HoldAfter   = 60;       // results seen before the long receiver hold
  localparam int HoldCycles  = 80;
  localparam int FrameBytes  = 9;
  localparam int DigitZero   = 48;

  // Command targets
  localparam logic [TargetW-1:0] TgtMax1 = 3'd0;
  localparam logic [TargetW-1:0] TgtTime = 3'd4;

  typedef struct packed {
    event_t                   ev;
    logic                     cmd_valid;
    logic [TargetW-1:0]       target;
    logic signed [ValueW-1:0] value;
  } decode_t;

  typedef struct packed {
    logic    right;
    logic    left;
    logic    enter;
    char_t   ser;
    logic    fixed;
    decode_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  sckd_sample_if sample_ch ();
  sckd_result_if result_ch ();

  serial_command_and_key_event_decoder_top DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  // Predictor state
  char_t      frame_store [FrameBytes];
  logic [3:0] frame_pos = '0;
  string      hdr_text [5] = '{"PSMAX1X", "PSMAX2X", "PSMIN1X", "PSMIN2X", "PSTIMEX"};

  decode_t    pending_decodes [$];
  stim_row_t  directed_rows [$];
  logic       cur_fixed;
  decode_t    cur_want;
  int         sent_count   = 0;
  int         results_seen = 0;
  int         mismatches   = 0;
  int         cycle_count  = 0;
  bit         calm         = 0;

  function automatic decode_t quiet(event_t ev);
    decode_t d;
    d = '0;
    d.ev = ev;
    return d;
  endfunction

  // Key event and frame command for one sample; updates the frame store
  function automatic decode_t decode_sample(logic r, logic l, logic e, char_t ser);
    decode_t d;
    int      v;
    bit      hit;
    d = '0;
    d.ev = EvNone;
    if (r) d.ev = EvRight;
    if (l) d.ev = EvLeft;
    if (e) d.ev = EvEnter;
    if (frame_pos >= FrameBytes) frame_pos = '0;
    if (ser == CharP) frame_pos = '0;
    if (ser != CharNone) begin
      frame_store[frame_pos] = ser;
      frame_pos = frame_pos + 4'd1;
    end
    if (frame_pos == FrameBytes) begin
      frame_pos = '0;
      v = (int'(frame_store[7]) - DigitZero) * 10 + (int'(frame_store[8]) - DigitZero);
      for (int h = 0; h < 5; h++) begin
        hit = 1;
        for (int i = 0; i < 7; i++)
          if (frame_store[i] != char_t'(hdr_text[h][i])) hit = 0;
        if (hit && !d.cmd_valid) begin
          d.cmd_valid = 1'b1;
          d.target    = TargetW'(h);
          d.value     = v[ValueW-1:0];
        end
      end
    end
    // single-character commands beat the buttons
    if (ser == CharD) d.ev = EvRight;
    if (ser == CharA) d.ev = EvLeft;
    if (ser == CharE) d.ev = EvEnter;
    return d;
  endfunction

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timed out, %0d results outstanding", $time, pending_decodes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Monitor: check results against the oldest expectation, record accepted samples
  always @(posedge clk) begin
    decode_t exp_d;
    decode_t pred;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen <= results_seen + 1;
        if (pending_decodes.size() == 0) begin
          $display("%0t: unexpected result ev=%0d valid=%0d target=%0d value=%0d", $time,
                   result_ch.event_code, result_ch.command_valid, result_ch.command_target,
                   result_ch.command_value);
          mismatches <= mismatches + 1;
        end else begin
          exp_d = pending_decodes.pop_front();
          if (result_ch.event_code !== exp_d.ev
              || result_ch.command_valid !== exp_d.cmd_valid
              || result_ch.command_target !== exp_d.target
              || result_ch.command_value !== exp_d.value) begin
            $display({"%0t: mismatch: expected ev=%0d valid=%0d target=%0d value=%0d,",
                      " got ev=%0d valid=%0d target=%0d value=%0d"},
                     $time, exp_d.ev, exp_d.cmd_valid, exp_d.target, exp_d.value,
                     result_ch.event_code, result_ch.command_valid,
                     result_ch.command_target, result_ch.command_value);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        pred = decode_sample(sample_ch.button_right, sample_ch.button_left,
                             sample_ch.button_enter, sample_ch.serial_byte);
        pending_decodes.push_back(cur_fixed ? cur_want : pred);
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none in the closing stretch
  initial begin
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 0;
    result_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one sample, with an optional idle burst first; returns once it is taken
  task automatic send_item(logic r, logic l, logic e, char_t ser, logic fixed, decode_t want);
    if (!calm && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        sample_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    sample_ch.valid        <= 1'b1;
    sample_ch.button_right <= r;
    sample_ch.button_left  <= l;
    sample_ch.button_enter <= e;
    sample_ch.serial_byte  <= ser;
    cur_fixed = fixed;
    cur_want  = want;
    do @(posedge clk); while (!sample_ch.ready);
    sent_count++;
    if (sent_count >= CalmFrom) calm = 1;
  endtask

  function automatic logic rand_btn();
    return ($urandom_range(0, 3) == 0);
  endfunction

  // Value character: mostly a digit, sometimes any non-zero byte
  function automatic char_t value_char();
    if ($urandom_range(0, 4) != 0) return char_t'(DigitZero + $urandom_range(0, 9));
    return char_t'($urandom_range(1, 255));
  endfunction

  // One frame: well formed, or with a corrupted character, or cut short
  task automatic send_frame(bit broken);
    char_t chars [FrameBytes];
    int    h;
    int    len;
    h   = $urandom_range(0, 4);
    len = FrameBytes;
    for (int i = 0; i < 7; i++) chars[i] = char_t'(hdr_text[h][i]);
    chars[7] = value_char();
    chars[8] = value_char();
    if (broken) begin
      if ($urandom_range(0, 1) == 0)
        chars[$urandom_range(1, 6)] = char_t'($urandom_range(1, 255));
      else
        len = $urandom_range(1, FrameBytes - 1);
    end
    for (int i = 0; i < len; i++) begin
      // empty samples between characters, with buttons
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
        send_item(rand_btn(), rand_btn(), rand_btn(), CharNone, 1'b0, '0);
      send_item(rand_btn(), rand_btn(), rand_btn(), chars[i], 1'b0, '0);
    end
  endtask

  task automatic send_noise();
    char_t c;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 5))
        0:       c = CharD;
        1:       c = CharA;
        2:       c = CharE;
        3:       c = CharNone;
        default: c = char_t'($urandom_range(0, 255));
      endcase
      send_item(rand_btn(), rand_btn(), rand_btn(), c, 1'b0, '0);
    end
  endtask

  // Stimulus and end of run
  initial begin
    int pick;
    rst                    = 1'b1;
    sample_ch.valid        = 1'b0;
    sample_ch.button_right = 1'b0;
    sample_ch.button_left  = 1'b0;
    sample_ch.button_enter = 1'b0;
    sample_ch.serial_byte  = CharNone;
    cur_fixed              = 1'b0;
    cur_want               = '0;

    // buttons alone, priority, serial commands over buttons
    directed_rows.push_back('{1'b0, 1'b0, 1'b0, CharNone, 1'b1, quiet(EvNone)});
    directed_rows.push_back('{1'b1, 1'b0, 1'b0, CharNone, 1'b1, quiet(EvRight)});
    directed_rows.push_back('{1'b0, 1'b1, 1'b0, CharNone, 1'b1, quiet(EvLeft)});
    directed_rows.push_back('{1'b0, 1'b0, 1'b1, CharNone, 1'b1, quiet(EvEnter)});
    directed_rows.push_back('{1'b1, 1'b1, 1'b1, CharNone, 1'b1, quiet(EvEnter)});
    directed_rows.push_back('{1'b1, 1'b1, 1'b0, CharNone, 1'b1, quiet(EvLeft)});
    directed_rows.push_back('{1'b0, 1'b0, 1'b1, CharD,    1'b1, quiet(EvRight)});
    directed_rows.push_back('{1'b1, 1'b0, 1'b0, CharA,    1'b1, quiet(EvLeft)});
    directed_rows.push_back('{1'b0, 1'b0, 1'b0, CharE,    1'b1, quiet(EvEnter)});
    // partial frame, then a restart in mid frame
    directed_rows.push_back('{1'b0, 1'b0, 1'b0, CharP,    1'b1, quiet(EvNone)});
    directed_rows.push_back('{1'b0, 1'b0, 1'b0, "S",      1'b1, quiet(EvNone)});
    for (int i = 0; i < 7; i++)
      directed_rows.push_back('{1'b0, 1'b0, 1'b0, char_t'(hdr_text[TgtTime][i]), 1'b0, '0});
    // largest value: both value characters 0xFF
    directed_rows.push_back('{1'b0, 1'b0, 1'b0, 8'hFF, 1'b0, '0});
    directed_rows.push_back('{1'b1, 1'b1, 1'b1, 8'hFF, 1'b1,
                              '{EvEnter, 1'b1, TgtTime, 13'sd2277}});
    // smallest value via a max-1 frame with 0x01 value characters
    for (int i = 0; i < 7; i++)
      directed_rows.push_back('{1'b0, 1'b0, 1'b0, char_t'(hdr_text[TgtMax1][i]), 1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, 1'b0, 8'h01, 1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, 1'b0, 8'h01, 1'b1,
                              '{EvNone, 1'b1, TgtMax1, -13'sd517}});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].right, directed_rows[i].left, directed_rows[i].enter,
                directed_rows[i].ser, directed_rows[i].fixed, directed_rows[i].want);

    // sender pause until everything has drained
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    wait (pending_decodes.size() == 0);

    while (sent_count < TotalItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      send_frame(1'b0);
      else if (pick < 85) send_frame(1'b1);
      else                send_noise();
    end

    @(negedge clk);
    sample_ch.valid <= 1'b0;
    wait (pending_decodes.size() == 0);
    repeat (5) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sckd_pkg.sv
rtl/sckd_if.sv
rtl/sckd_frame.sv
rtl/serial_command_and_key_event_decoder_top.sv
bench/serial_command_and_key_event_decoder_top_test.sv
